// ===== design/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants of the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int FIELD_W  = 16;
   localparam int ARG_W    = 17;   // clamped root argument, Q14, unsigned
   localparam int ROOT_W   = 18;   // root in Q16
   localparam int REM_W    = 21;   // root remainder
   localparam int MAG_W    = 17;   // magnitude of an element sum or difference
   localparam int DIFF_W   = 18;   // signed element sum or difference
   localparam int QUO_W    = 15;   // quotient bits below saturation
   localparam int NUM_W    = 33;   // dividend and running remainder
   localparam int SQRT_ST  = 18;   // one root bit per stage
   localparam int ARG_PAIRS = 9;   // stages that still take argument bits
   localparam int LAST_ST  = 1 + SQRT_ST + 1 + QUO_W - 1;

   localparam logic signed [18:0] Q_ONE = 19'sd16384;

   // Output slot that holds the main component.
   typedef enum logic [1:0] {
      SLOT_W = 2'd0,
      SLOT_X = 2'd1,
      SLOT_Y = 2'd2,
      SLOT_Z = 2'd3
   } slot_type;

   typedef struct packed {
      slot_type                       main_sel;
      logic [ARG_W-1:0]               arg;
      logic [REM_W-1:0]               rem;
      logic [ROOT_W-1:0]              root;
      logic [3:0]                     dneg;
      logic [3:0][MAG_W-1:0]          dmag;
      logic [3:0]                     sat;
      logic [3:0][NUM_W-1:0]          num;
      logic [3:0][QUO_W-1:0]          quo;
   } stage_type;

endpackage

// ===== design/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Converts a 3x3 rotation matrix in Q2.14 to a unit quaternion in Q2.14.
// ----------------------------------------------------------------------------
// The block takes one matrix item per cycle while req_stall is low and returns
// one quaternion item per matrix, in order. The path holds 36 register stages:
// an input stage, the restoring square root, which resolves one root bit per
// stage (18 stages), a divider setup stage, four restoring dividers working
// side by side that resolve one quotient bit per stage (15 stages), and the
// output register. When the output is stalled with a result waiting, the whole
// pipeline holds and req_stall rises; nothing is dropped or repeated.
// The method is Shoemake's: with a positive trace the scalar part comes from
// the root, otherwise the largest diagonal element (lower index on ties)
// picks the component that does. Results saturate to 16 bits.
module rotation_matrix_to_quaternion_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z
);

   localparam int LAST = rmq_pkg::LAST_ST;

   // The pipeline moves as one unless a finished item waits at the output.
   logic advance;
   logic [LAST:0] vld_ff;
   logic rsp_valid_ff;
   rmq_pkg::stage_type pipe_ff [0:LAST];
   rmq_pkg::stage_type pipe_in [0:LAST];
   logic signed [15:0] quat_ff [0:3];
   logic signed [15:0] quat_in [0:3];

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_quat_w = quat_ff[0];
   assign rsp_quat_x = quat_ff[1];
   assign rsp_quat_y = quat_ff[2];
   assign rsp_quat_z = quat_ff[3];

   // ---------------------------------------------------------------------
   // Input stage: trace, branch choice, root argument and the four signed
   // element sums or differences routed to their output slots.
   // ---------------------------------------------------------------------
   logic signed [18:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
   logic signed [18:0] trace, arg_raw;
   logic signed [18:0] dv [0:3];
   rmq_pkg::slot_type  sel;

   always_comb begin
      a00 = 19'(req_m00); a01 = 19'(req_m01); a02 = 19'(req_m02);
      a10 = 19'(req_m10); a11 = 19'(req_m11); a12 = 19'(req_m12);
      a20 = 19'(req_m20); a21 = 19'(req_m21); a22 = 19'(req_m22);
      trace = a00 + a11 + a22;
      if (trace > 19'sd0) begin
         sel     = rmq_pkg::SLOT_W;
         arg_raw = trace + rmq_pkg::Q_ONE;
         dv[0]   = 19'sd0;
         dv[1]   = a21 - a12;
         dv[2]   = a02 - a20;
         dv[3]   = a10 - a01;
      end else if (a22 > a00 && a22 > a11) begin
         sel     = rmq_pkg::SLOT_Z;
         arg_raw = a22 - a00 - a11 + rmq_pkg::Q_ONE;
         dv[0]   = a10 - a01;
         dv[1]   = a02 + a20;
         dv[2]   = a12 + a21;
         dv[3]   = 19'sd0;
      end else if (a11 > a00) begin
         sel     = rmq_pkg::SLOT_Y;
         arg_raw = a11 - a22 - a00 + rmq_pkg::Q_ONE;
         dv[0]   = a02 - a20;
         dv[1]   = a01 + a10;
         dv[2]   = 19'sd0;
         dv[3]   = a21 + a12;
      end else begin
         sel     = rmq_pkg::SLOT_X;
         arg_raw = a00 - a11 - a22 + rmq_pkg::Q_ONE;
         dv[0]   = a21 - a12;
         dv[1]   = 19'sd0;
         dv[2]   = a10 + a01;
         dv[3]   = a20 + a02;
      end

      pipe_in[0] = '0;
      pipe_in[0].main_sel = sel;
      // A root argument at or below zero is clamped to the smallest step.
      pipe_in[0].arg = (arg_raw <= 19'sd0) ? rmq_pkg::ARG_W'(1)
                                            : arg_raw[rmq_pkg::ARG_W-1:0];
      for (int s = 0; s < 4; s++) begin
         pipe_in[0].dneg[s] = dv[s][18];
         pipe_in[0].dmag[s] = dv[s][18] ? rmq_pkg::MAG_W'(-dv[s])
                                        : dv[s][rmq_pkg::MAG_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Square root stages: one root bit each, two argument bits shifted in.
   // The low 18 bits of the radicand are zero, so later stages shift zeros.
   // ---------------------------------------------------------------------
   genvar gk;
   generate
      for (gk = 0; gk < rmq_pkg::SQRT_ST; gk++) begin : g_sqrt
         logic [1:0]                 pair;
         logic [rmq_pkg::REM_W-1:0]  rem_sh, trial;
         if (gk < rmq_pkg::ARG_PAIRS) begin : g_pair
            logic [rmq_pkg::ROOT_W-1:0] arg_pad;
            assign arg_pad = {1'b0, pipe_ff[gk].arg};
            assign pair    = arg_pad[rmq_pkg::ROOT_W-1-2*gk -: 2];
         end else begin : g_zero
            assign pair = 2'b00;
         end
         always_comb begin
            rem_sh = {pipe_ff[gk].rem[rmq_pkg::REM_W-3:0], pair};
            trial  = {1'b0, pipe_ff[gk].root, 2'b01};
            pipe_in[gk+1] = pipe_ff[gk];
            if (rem_sh >= trial) begin
               pipe_in[gk+1].rem  = rem_sh - trial;
               pipe_in[gk+1].root = {pipe_ff[gk].root[rmq_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               pipe_in[gk+1].rem  = rem_sh;
               pipe_in[gk+1].root = {pipe_ff[gk].root[rmq_pkg::ROOT_W-2:0], 1'b0};
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Divider setup: dividend is |d| * 2^15 plus half the root for rounding.
   // A quotient of 2^15 or more saturates, so only 15 bits are resolved.
   // ---------------------------------------------------------------------
   localparam int DSET = rmq_pkg::SQRT_ST + 1;

   always_comb begin
      pipe_in[DSET] = pipe_ff[DSET-1];
      for (int s = 0; s < 4; s++) begin
         pipe_in[DSET].num[s] = {1'b0, pipe_ff[DSET-1].dmag[s], 15'd0}
                              + rmq_pkg::NUM_W'(pipe_ff[DSET-1].root >> 1);
         pipe_in[DSET].sat[s] = pipe_in[DSET].num[s]
                              >= {pipe_ff[DSET-1].root, 15'd0};
         pipe_in[DSET].quo[s] = '0;
      end
   end

   generate
      for (gk = 0; gk < rmq_pkg::QUO_W; gk++) begin : g_div
         localparam int BIT = rmq_pkg::QUO_W - 1 - gk;
         logic [rmq_pkg::NUM_W-1:0] dsh;
         always_comb begin
            dsh = rmq_pkg::NUM_W'(pipe_ff[DSET+gk].root) << BIT;
            pipe_in[DSET+gk+1] = pipe_ff[DSET+gk];
            for (int s = 0; s < 4; s++) begin
               if (pipe_ff[DSET+gk].num[s] >= dsh) begin
                  pipe_in[DSET+gk+1].num[s]      = pipe_ff[DSET+gk].num[s] - dsh;
                  pipe_in[DSET+gk+1].quo[s][BIT] = 1'b1;
               end
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Output stage: main component from the root, the rest from the quotients.
   // ---------------------------------------------------------------------
   logic [rmq_pkg::ROOT_W:0] main_val;

   always_comb begin
      main_val = ({1'b0, pipe_ff[LAST].root} + 19'd4) >> 3;
      for (int s = 0; s < 4; s++) begin
         if (rmq_pkg::slot_type'(s) == pipe_ff[LAST].main_sel) begin
            quat_in[s] = (main_val > 19'd32767) ? 16'sh7fff : 16'(main_val);
         end else if (pipe_ff[LAST].sat[s]) begin
            quat_in[s] = pipe_ff[LAST].dneg[s] ? 16'sh8000 : 16'sh7fff;
         end else if (pipe_ff[LAST].dneg[s]) begin
            quat_in[s] = -$signed({1'b0, pipe_ff[LAST].quo[s]});
         end else begin
            quat_in[s] = $signed({1'b0, pipe_ff[LAST].quo[s]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[LAST-1:0], req_valid};
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= LAST; s++) begin
            pipe_ff[s] <= pipe_in[s];
         end
         for (int s = 0; s < 4; s++) begin
            quat_ff[s] <= quat_in[s];
         end
      end
   end

endmodule

// ===== design/rmq_checker.sv =====
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the quaternion pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rmq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_quat_w,
   input logic [15:0] rsp_quat_x,
   input logic [15:0] rsp_quat_y,
   input logic [15:0] rsp_quat_z
);

   // The input only backs up when a finished item is held at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // No result comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_quat_w)
         && $stable(rsp_quat_x) && $stable(rsp_quat_y) && $stable(rsp_quat_z)))
      else $error("held result changed");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_quat_w (rsp_quat_w),
   .rsp_quat_x (rsp_quat_x),
   .rsp_quat_y (rsp_quat_y),
   .rsp_quat_z (rsp_quat_z)
);

// ===== tb/tb_rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_core
// Self-checking bench for the matrix to quaternion pipeline. A short table of
// directed matrices is followed by random matrices, mostly near-rotations,
// with random idling on both channels and a long output hold-off. Every
// quaternion is compared with an in-bench fixed-point model of the method.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_core;

   localparam int N_RANDOM   = 1800;
   localparam int LATENCY    = 36;
   localparam int CYCLE_MAX  = 400000;
   localparam int N_DIRECTED = 16;

   typedef struct {
      logic signed [15:0] m [9];
   } matrix_type;

   typedef struct {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   // Directed rows: nine elements, whether the quaternion is typed in, and
   // that quaternion.
   typedef struct {
      logic signed [15:0] m [9];
      bit                 known;
      quat_type           q;
   } vector_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_m [9];
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_type   quat_queue[$];
   int         cycle_count;
   int         fail_count;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         hold_cycles;
   vector_type vectors [N_DIRECTED];

   rotation_matrix_to_quaternion_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_m00    (req_m[0]),
      .req_m01    (req_m[1]),
      .req_m02    (req_m[2]),
      .req_m10    (req_m[3]),
      .req_m11    (req_m[4]),
      .req_m12    (req_m[5]),
      .req_m20    (req_m[6]),
      .req_m21    (req_m[7]),
      .req_m22    (req_m[8]),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_quat_w (rsp_quat_w),
      .rsp_quat_x (rsp_quat_x),
      .rsp_quat_y (rsp_quat_y),
      .rsp_quat_z (rsp_quat_z)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Integer square root, one result bit per pass.
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // d * 2^15 / root, rounded half away from zero, then saturated.
   function automatic logic signed [15:0] scale_by_root(longint d, longint unsigned r);
      longint unsigned mag;
      longint q;
      mag = (d < 0 ? -d : d) << 15;
      q = longint'((mag + (r >> 1)) / r);
      return clip16(d < 0 ? -q : q);
   endfunction

   // Expected quaternion of one matrix, by Shoemake's method.
   function automatic quat_type matrix_to_quat(matrix_type mx);
      longint e [3][3];
      longint trace, arg;
      longint unsigned root;
      logic signed [15:0] qv [3];
      quat_type q;
      int i, j, k;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            e[a][b] = mx.m[a*3+b];
      trace = e[0][0] + e[1][1] + e[2][2];
      if (trace > 0) begin
         arg = trace + 16384;
         root = int_sqrt(longint'(arg) << 18);
         q.w = clip16(longint'((root + 4) >> 3));
         qv[0] = scale_by_root(e[2][1] - e[1][2], root);
         qv[1] = scale_by_root(e[0][2] - e[2][0], root);
         qv[2] = scale_by_root(e[1][0] - e[0][1], root);
      end else begin
         // Lower index wins a tie on the diagonal.
         i = 0;
         if (e[1][1] > e[0][0]) i = 1;
         if (e[2][2] > e[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         arg = e[i][i] - e[j][j] - e[k][k] + 16384;
         // A non-positive root argument is clamped to one Q14 step.
         if (arg <= 0) arg = 1;
         root = int_sqrt(longint'(arg) << 18);
         qv[i] = clip16(longint'((root + 4) >> 3));
         q.w   = scale_by_root(e[k][j] - e[j][k], root);
         qv[j] = scale_by_root(e[j][i] + e[i][j], root);
         qv[k] = scale_by_root(e[k][i] + e[i][k], root);
      end
      q.x = qv[0];
      q.y = qv[1];
      q.z = qv[2];
      return q;
   endfunction

   function automatic vector_type make_row(int m0, int m1, int m2, int m3, int m4,
                                           int m5, int m6, int m7, int m8);
      vector_type v;
      v.m = '{16'(m0), 16'(m1), 16'(m2), 16'(m3), 16'(m4),
              16'(m5), 16'(m6), 16'(m7), 16'(m8)};
      v.known = 1'b0;
      v.q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
      return v;
   endfunction

   // Mostly scaled near-rotations (permutations with signs plus noise), the
   // rest fully random bit patterns.
   function automatic matrix_type random_matrix();
      matrix_type mx;
      int perm [3];
      int noise;
      if ($urandom_range(0, 3) == 0) begin
         foreach (mx.m[n]) mx.m[n] = 16'($urandom());
      end else begin
         perm = '{0, 1, 2};
         perm.shuffle();
         noise = (1 << $urandom_range(0, 14));
         foreach (mx.m[n]) mx.m[n] = 16'($signed($urandom_range(0, noise)) - noise / 2);
         for (int r = 0; r < 3; r++)
            mx.m[r*3+perm[r]] = $urandom_range(0, 1)
                                ? 16'(16384 - mx.m[r*3+perm[r]] / 4)
                                : 16'(-16384 + mx.m[r*3+perm[r]] / 4);
      end
      return mx;
   endfunction

   task automatic send_matrix(matrix_type mx);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      foreach (mx.m[n]) req_m[n] <= mx.m[n];
      quat_queue.push_back(matrix_to_quat(mx));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (quat_queue.size() != 0) @(negedge clock);
   endtask

   // Receiver: random stalls, or a counted long hold-off when requested.
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(1, 100) <= recv_idle_pct);
         end
      end
   end

   // Checker: each accepted item is compared with the oldest expectation.
   always @(posedge clock) begin
      quat_type exp_q;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (quat_queue.size() == 0) begin
            $display("%0t: unexpected item w=%0d x=%0d y=%0d z=%0d", $time,
                     rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            fail_count++;
         end else begin
            exp_q = quat_queue.pop_front();
            if (rsp_quat_w !== exp_q.w) begin
               $display("%0t: quat_w expected %0d actual %0d", $time, exp_q.w, rsp_quat_w);
               fail_count++;
            end
            if (rsp_quat_x !== exp_q.x) begin
               $display("%0t: quat_x expected %0d actual %0d", $time, exp_q.x, rsp_quat_x);
               fail_count++;
            end
            if (rsp_quat_y !== exp_q.y) begin
               $display("%0t: quat_y expected %0d actual %0d", $time, exp_q.y, rsp_quat_y);
               fail_count++;
            end
            if (rsp_quat_z !== exp_q.z) begin
               $display("%0t: quat_z expected %0d actual %0d", $time, exp_q.z, rsp_quat_z);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on a cycle count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_MAX) begin
         $display("rotation_matrix_to_quaternion_core test failed");
         $finish;
      end
   end

   initial begin
      matrix_type mx;
      quat_type   pred;
      cycle_count   = 0;
      fail_count    = 0;
      hold_cycles   = 0;
      send_idle_pct = 16;
      recv_idle_pct = 88;
      reset     = 1'b1;
      req_valid = 1'b0;
      foreach (req_m[n]) req_m[n] = '0;

      // Identity: trace positive, w = 1.0 exactly, vector part zero.
      vectors[0] = make_row(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
      vectors[0].known = 1'b1;
      vectors[0].q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      // All zero: non-positive trace, x picked on the tie, root of one.
      vectors[1] = make_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
      vectors[1].known = 1'b1;
      vectors[1].q = '{16'sd0, 16'sd8192, 16'sd0, 16'sd0};
      // Half turns about each axis: each diagonal element wins once.
      vectors[2] = make_row(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
      vectors[3] = make_row(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
      vectors[4] = make_row(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
      // Ties on the diagonal with a non-positive trace.
      vectors[5] = make_row(-8192, 100, -200, 300, -8192, 400, -500, 600, -8192);
      vectors[6] = make_row(-16384, 1, 2, 3, 0, 4, 5, 6, 0);
      // Field extremes; the first has a non-positive trace, the second a positive one.
      vectors[7] = make_row(-32768, 32767, -32768, 32767, -32768, 32767,
                            -32768, 32767, -32768);
      vectors[8] = make_row(-32768, -32768, -32768, -32768, 32767,
                            -32768, -32768, -32768, 32767);
      // Field extremes with a positive trace.
      vectors[9] = make_row(32767, -32768, 32767, -32768, 32767, -32768,
                            32767, -32768, 32767);
      vectors[10] = make_row(32767, 32767, 32767, 32767, 32767, 32767,
                             32767, 32767, 32767);
      // Trace exactly zero and trace one step above zero.
      vectors[11] = make_row(16384, 1000, -2000, 3000, -8192, 4000, -5000, 6000, -8192);
      vectors[12] = make_row(1, 0, 0, 0, 0, 0, 0, 0, 0);
      // Quarter turns about z and x.
      vectors[13] = make_row(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);
      vectors[14] = make_row(16384, 0, 0, 0, 0, -16384, 0, 16384, 0);
      // Every bit set on every element.
      vectors[15] = make_row(-1, -1, -1, -1, -1, -1, -1, -1, -1);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (vectors[v]) begin
         mx.m = vectors[v].m;
         pred = matrix_to_quat(mx);
         if (vectors[v].known && (pred.w !== vectors[v].q.w || pred.x !== vectors[v].q.x
                                  || pred.y !== vectors[v].q.y
                                  || pred.z !== vectors[v].q.z)) begin
            $display("%0t: model row %0d expected w=%0d x=%0d y=%0d z=%0d", $time, v,
                     vectors[v].q.w, vectors[v].q.x, vectors[v].q.y, vectors[v].q.z);
            $display("%0t: model row %0d actual w=%0d x=%0d y=%0d z=%0d", $time, v,
                     pred.w, pred.x, pred.y, pred.z);
            fail_count++;
         end
         send_matrix(mx);
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 3) begin
            send_idle_pct = 88;
            recv_idle_pct = 16;
         end
         if (n == 2 * N_RANDOM / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // Long hold-off so the pipeline fills and req_stall rises.
            hold_cycles = 200;
         end
         // Sender pauses until every expected item is back.
         if (n == N_RANDOM / 2) drain();
         send_matrix(random_matrix());
      end

      drain();
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0) begin
         $display("rotation_matrix_to_quaternion_core test passed");
      end else begin
         $display("rotation_matrix_to_quaternion_core test failed");
      end
      $finish;
   end

endmodule
